### rtl/unaligned_memory_access_unit_macros.svh
// ----------------------------------------------------------------------------
// Unaligned memory access unit: assertion macros
// Shared concurrent-assertion shorthands, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UNALIGNED_MEMORY_ACCESS_UNIT_MACROS_SVH
`define UNALIGNED_MEMORY_ACCESS_UNIT_MACROS_SVH

// same-cycle implication
`define UMAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UMAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/umau_pkg.sv
// ----------------------------------------------------------------------------
// Unaligned memory access unit: package
// Types and fixed constants shared by the unit and its longword RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package umau_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SIZE_W    = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 1'b1;

  localparam logic [DATA_W-1:0] ADDR_MASK_RST = 32'h3FFF_FFFF;
  localparam logic [SIZE_W-1:0] MEM_SIZE_RST  = 17'h1_0000;

  // lane masks for each access width
  localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [DATA_W-1:0] MASK_WORD = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] MASK_LONG = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    SZ_BYTE,
    SZ_WORD,
    SZ_LONG
  } size_e;

  // RAM write beat (address travels separately, its width is a parameter)
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

### rtl/unaligned_memory_access_unit.sv
// Result: a beat accepted in idle goes to lookup, whose result is registered on
//   read_data_o, with done_o high for a single cycle (writes return zero).
// Occupancy: a new beat waits for idle; with the single RAM write port, a write split
//   over two longwords adds a high-half state (read, write low half, then high half).
// Reset: config registers take their reset values, then a clearing pass zeroes the
//   RAM one longword per cycle, up to index MEM_LONGWORDS-1, with busy held high.
// ----------------------------------------------------------------------------
// Unaligned memory access unit
// Little-endian byte-addressed memory of 32-bit longwords with byte, word and
// longword access at any alignment; split writes read-modify-write both halves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unaligned_memory_access_unit_macros.svh"

module unaligned_memory_access_unit #(
  parameter int unsigned MEM_LONGWORDS = 16384
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           operation_i,
  input  wire logic [31:0]                    address_i,
  input  wire logic [2:0]                     access_size_i,
  input  wire logic [umau_pkg::DATA_W-1:0]    write_data_i,
  // result channel
  output logic                                done_o,
  output logic      [umau_pkg::DATA_W-1:0]    read_data_o,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [umau_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [umau_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import umau_pkg::*;

  localparam int unsigned IDX_W = $clog2(MEM_LONGWORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_LONGWORDS - 1);
  localparam logic [30:0] MEM_LW_C = 31'(MEM_LONGWORDS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITE_HI
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers: written whenever the enable is high.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] addr_mask_q;
  logic [SIZE_W-1:0] mem_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_mask_q <= ADDR_MASK_RST;
      mem_size_q  <= MEM_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ADDR_MASK: addr_mask_q <= cfg_wdata_i;
        CFG_MEM_SIZE:  mem_size_q  <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Address decode at accept: mask, classify, form both longword addresses
  // and their range checks.
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic              accept;
  logic [31:0]       pa, pa1, size_bytes;
  size_e             size_d;
  logic              aligned, split_d, lo_ok_d, hi_ok_d;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    case (access_size_i)
      3'd2:    size_d = SZ_WORD;
      3'd4:    size_d = SZ_LONG;
      default: size_d = SZ_BYTE;
    endcase
  end

  always_comb begin
    case (size_d)
      SZ_WORD: size_bytes = 32'd2;
      SZ_LONG: size_bytes = 32'd4;
      default: size_bytes = 32'd1;
    endcase
  end

  assign pa  = address_i & addr_mask_q;
  assign pa1 = (pa + size_bytes) & addr_mask_q;

  always_comb begin
    case (size_d)
      SZ_WORD: aligned = !pa[0];
      SZ_LONG: aligned = (pa[1:0] == 2'd0);
      default: aligned = 1'b1;
    endcase
  end

  // A misaligned word at offset 1 still sits inside one longword.
  assign split_d = !aligned && ((size_d == SZ_LONG) || (pa[1:0] == 2'd3));

  assign lo_ok_d = (pa  < 32'(mem_size_q)) && ({1'b0, pa[31:2]}  < MEM_LW_C);
  assign hi_ok_d = (pa1 < 32'(mem_size_q)) && ({1'b0, pa1[31:2]} < MEM_LW_C);

  // --------------------------------------------------------------------------
  // Beat payload held across the lookup and write-back cycles.
  // --------------------------------------------------------------------------
  logic              op_q, split_q, lo_ok_q, hi_ok_q;
  size_e             size_q;
  logic [1:0]        boff_q;
  logic [DATA_W-1:0] wdata_q, hi_new_q;
  logic [IDX_W-1:0]  lo_idx_q, hi_idx_q;

  // --------------------------------------------------------------------------
  // Merge and modify: the two longwords form a 64-bit window that is
  // shifted by the byte offset, which serves every size and alignment.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0]   rd_lo, rd_hi, lw, hw, lane_mask, res;
  logic [2*DATA_W-1:0] window, merged, wmask, wdata_sh, new_win;
  logic [5:0]          shamt;

  assign lw = lo_ok_q ? rd_lo : '0;
  assign hw = hi_ok_q ? rd_hi : '0;

  always_comb begin
    case (size_q)
      SZ_WORD: lane_mask = MASK_WORD;
      SZ_LONG: lane_mask = MASK_LONG;
      default: lane_mask = MASK_BYTE;
    endcase
  end

  assign shamt    = {1'b0, boff_q, 3'b000};
  assign window   = {hw, lw};
  assign merged   = window >> shamt;
  assign res      = merged[DATA_W-1:0] & lane_mask;
  assign wmask    = {{DATA_W{1'b0}}, lane_mask} << shamt;
  assign wdata_sh = {{DATA_W{1'b0}}, wdata_q & lane_mask} << shamt;
  assign new_win  = (window & ~wmask) | wdata_sh;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      size_q   <= size_d;
      boff_q   <= pa[1:0];
      split_q  <= split_d;
      lo_ok_q  <= lo_ok_d;
      hi_ok_q  <= hi_ok_d;
      wdata_q  <= write_data_i;
      lo_idx_q <= pa[IDX_W+1:2];
      hi_idx_q <= pa1[IDX_W+1:2];
    end
    // Hold the high half from the original read so it wins when both halves
    // land in the same longword.
    if (state_q == ST_LOOKUP) begin
      hi_new_q <= new_win[2*DATA_W-1:DATA_W];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, clearing counter and registered result.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] clr_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE:     if (start) state_d = ST_LOOKUP;
      ST_LOOKUP:   state_d = (op_q && split_q) ? ST_WRITE_HI : ST_IDLE;
      ST_WRITE_HI: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      done_o      <= 1'b0;
      read_data_o <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == ST_LOOKUP);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (state_q == ST_LOOKUP) begin
        read_data_o <= op_q ? '0 : res;
      end
    end
  end

  // --------------------------------------------------------------------------
  // RAM write port: clearing sweep, low half at lookup, high half after.
  // --------------------------------------------------------------------------
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] ram_wr_addr;

  always_comb begin
    ram_wr.en   = 1'b0;
    ram_wr.data = '0;
    ram_wr_addr = lo_idx_q;
    case (state_q)
      ST_CLEAR: begin
        ram_wr.en   = 1'b1;
        ram_wr_addr = clr_q;
      end
      ST_LOOKUP: begin
        ram_wr.en   = op_q && lo_ok_q;
        ram_wr.data = new_win[DATA_W-1:0];
      end
      ST_WRITE_HI: begin
        ram_wr.en   = hi_ok_q;
        ram_wr.data = hi_new_q;
        ram_wr_addr = hi_idx_q;
      end
      default: ;
    endcase
  end

  umau_ram #(
    .DEPTH  (MEM_LONGWORDS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_i        (ram_wr),
    .wr_addr_i   (ram_wr_addr),
    .rd_en_i     (accept),
    .rd_addr_a_i (pa[IDX_W+1:2]),
    .rd_addr_b_i (pa1[IDX_W+1:2]),
    .rd_data_a_o (rd_lo),
    .rd_data_b_o (rd_hi)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `UMAU_ASSERT_NEXT(a_accept_lookup, clk_i, rst_ni, accept, state_q == ST_LOOKUP, "accepted beat did not enter lookup")
  `UMAU_ASSERT_NEXT(a_lookup_done, clk_i, rst_ni, state_q == ST_LOOKUP, done_o, "lookup gave no result strobe")
  `UMAU_ASSERT_NOW(a_hi_after_lookup, clk_i, rst_ni, state_q == ST_WRITE_HI, $past(state_q == ST_LOOKUP) && $past(op_q && split_q), "high-half write without split write")

endmodule

`default_nettype wire

### rtl/umau_ram.sv
// ----------------------------------------------------------------------------
// Unaligned memory access unit: longword RAM
// One write port and two read ports sharing a read enable; read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module umau_ram #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14
) (
  input  wire logic                        clk_i,
  input  wire umau_pkg::ram_wr_t           wr_i,
  input  wire logic [ADDR_W-1:0]           wr_addr_i,
  input  wire logic                        rd_en_i,
  input  wire logic [ADDR_W-1:0]           rd_addr_a_i,
  input  wire logic [ADDR_W-1:0]           rd_addr_b_i,
  output logic      [umau_pkg::DATA_W-1:0] rd_data_a_o,
  output logic      [umau_pkg::DATA_W-1:0] rd_data_b_o
);
  import umau_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

### verif/umau_tb_pkg.sv
// ----------------------------------------------------------------------------
// Unaligned memory access unit: verification constants
// Operation and access-width codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package umau_tb_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] ACC_BYTE = 3'd1;
  localparam logic [2:0] ACC_WORD = 3'd2;
  localparam logic [2:0] ACC_LONG = 3'd4;

endpackage

### verif/umau_checker.sv
// ----------------------------------------------------------------------------
// Unaligned memory access unit: checker
// Shadows the longword memory and both configuration registers, predicts the
// read data of every accepted command and compares it with each done strobe.
// ----------------------------------------------------------------------------
module umau_checker #(
  parameter int unsigned MEM_LONGWORDS = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           operation_i,
  input  logic [31:0]                    address_i,
  input  logic [2:0]                     access_size_i,
  input  logic [umau_pkg::DATA_W-1:0]    write_data_i,
  input  logic                           done_i,
  input  logic [umau_pkg::DATA_W-1:0]    read_data_i,
  input  logic                           cfg_we_i,
  input  logic [umau_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [umau_pkg::DATA_W-1:0]    cfg_wdata_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import umau_pkg::*;
  import umau_tb_pkg::*;

  // byte-lane keep masks for misaligned words
  localparam logic [31:0] KEEP_OUTER = 32'hFF00_00FF;
  localparam logic [31:0] KEEP_LOW3  = 32'h00FF_FFFF;
  localparam logic [31:0] KEEP_HIGH3 = 32'hFFFF_FF00;

  logic [31:0]       shadow_mem [MEM_LONGWORDS];
  logic [31:0]       addr_mask_q;
  logic [SIZE_W-1:0] mem_size_q;
  logic [31:0]       expected_read_data [$];
  logic [31:0]       exp_data;

  function automatic logic in_range(input logic [31:0] pa);
    return (pa < {15'd0, mem_size_q}) && ((pa >> 2) < MEM_LONGWORDS);
  endfunction

  function automatic logic [31:0] rd_long(input logic [31:0] pa);
    return in_range(pa) ? shadow_mem[pa >> 2] : 32'd0;
  endfunction

  function automatic void wr_long(input logic [31:0] pa, input logic [31:0] v);
    if (in_range(pa)) shadow_mem[pa >> 2] = v;
  endfunction

  // Apply one command to the shadow memory and return the data it reads.
  function automatic logic [31:0] predict_read_data(input logic op, input logic [31:0] addr,
                                                    input logic [2:0] size,
                                                    input logic [31:0] wdata);
    logic [31:0] pa, pa1, lw, m, dl, dh, keep, res, step;
    logic [1:0]  boff;
    int unsigned sc;
    step = (size == ACC_WORD || size == ACC_LONG) ? {29'd0, size} : 32'd1;
    pa   = addr & addr_mask_q;
    pa1  = (pa + step) & addr_mask_q;
    boff = pa[1:0];
    sc   = boff * 8;
    res  = '0;
    if ((pa & (step - 1)) == 0) begin
      lw = rd_long(pa);
      m  = (step == 4) ? MASK_LONG : (step == 2) ? MASK_WORD : MASK_BYTE;
      if (op == OP_READ) res = (lw >> sc) & m;
      else if (in_range(pa)) wr_long(pa, (lw & ~(m << sc)) | ((wdata & m) << sc));
    end else if (step == 2) begin
      dl = rd_long(pa);
      if (boff == 2'd1) begin
        if (op == OP_READ) res = (dl >> 8) & MASK_WORD;
        else wr_long(pa, (dl & KEEP_OUTER) | ((wdata & MASK_WORD) << 8));
      end else begin
        dh = rd_long(pa1);
        if (op == OP_READ) begin
          res = ((dl >> 24) | (dh << 8)) & MASK_WORD;
        end else begin
          wr_long(pa, (dl & KEEP_LOW3) | ((wdata & MASK_BYTE) << 24));
          wr_long(pa1, (dh & KEEP_HIGH3) | ((wdata >> 8) & MASK_BYTE));
        end
      end
    end else begin
      // split longword: both halves are read before either is written
      dl   = rd_long(pa);
      dh   = rd_long(pa1);
      keep = MASK_LONG >> (32 - sc);
      if (op == OP_READ) begin
        res = (dl >> sc) | (dh << (32 - sc));
      end else begin
        wr_long(pa, (dl & keep) | (wdata << sc));
        wr_long(pa1, (dh & ~keep) | (wdata >> (32 - sc)));
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      addr_mask_q = ADDR_MASK_RST;
      mem_size_q  = MEM_SIZE_RST;
      expected_read_data.delete();
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (expected_read_data.size() == 0) begin
          $error("read_data: unexpected result beat, actual %h", read_data_i);
          fail_count_o++;
        end else begin
          exp_data = expected_read_data.pop_front();
          if (read_data_i !== exp_data) begin
            $error("read_data: expected %h, actual %h", exp_data, read_data_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ADDR_MASK) addr_mask_q = cfg_wdata_i;
        else if (cfg_index_i == CFG_MEM_SIZE) mem_size_q = cfg_wdata_i[SIZE_W-1:0];
      end
      if (start_i && !busy_i) begin
        expected_read_data.push_back(
          predict_read_data(operation_i, address_i, access_size_i, write_data_i));
      end
    end
    pending_o = expected_read_data.size();
  end

endmodule

### verif/tb_unaligned_memory_access_unit.sv
// ----------------------------------------------------------------------------
// Unaligned memory access unit: regression testbench
// Drives directed and random byte, word and longword commands at every
// alignment across several address-mask and memory-size settings, and leaves
// prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_unaligned_memory_access_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import umau_pkg::*;
  import umau_tb_pkg::*;

  localparam int unsigned MEM_LONGWORDS = 16384;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 operation_i;
  logic [31:0]          address_i;
  logic [2:0]           access_size_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 done_o;
  logic [DATA_W-1:0]    read_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_wdata_i;
  int unsigned          fail_count;
  int unsigned          pending;

  // current settings, mirrored here only to aim addresses at the edges
  logic [31:0]          cur_mask;
  logic [SIZE_W-1:0]    cur_size;
  int unsigned          beat_count;

  unaligned_memory_access_unit #(
    .MEM_LONGWORDS(MEM_LONGWORDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .access_size_i(access_size_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  umau_checker #(
    .MEM_LONGWORDS(MEM_LONGWORDS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .access_size_i(access_size_i),
    .write_data_i (write_data_i),
    .done_i       (done_o),
    .read_data_i  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Offer one command beat. Idle gaps come first, each cycle idling with a
  // chance of about 26 in 100, except inside the quiet stretch. The beat is
  // presented at a falling edge and held until a rising edge sees busy low.
  task automatic send_cmd(input logic op, input logic [31:0] addr,
                          input logic [2:0] size, input logic [31:0] wdata);
    logic quiet;
    quiet = (beat_count >= 700) && (beat_count < 850);
    while (!quiet && ($urandom_range(0, 99) < 26)) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    operation_i   <= op;
    address_i     <= addr;
    access_size_i <= size;
    write_data_i  <= wdata;
    do @(posedge clk_i); while (busy);
    beat_count++;
  endtask

  // Drop start, let every expected result come home and the split-write tail
  // settle, then wait for the block to report idle.
  task automatic drain;
    int unsigned guard;
    @(negedge clk_i);
    start <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  // Write both registers back to back, only ever with the block idle.
  task automatic set_config(input logic [31:0] mask, input logic [SIZE_W-1:0] size);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ADDR_MASK;
    cfg_wdata_i <= mask;
    @(negedge clk_i);
    cfg_index_i <= CFG_MEM_SIZE;
    cfg_wdata_i <= {{(DATA_W-SIZE_W){1'b0}}, size};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mask = mask;
    cur_size = size;
  endtask

  // Mostly legal widths, with the odd codes that fall back to a byte.
  function automatic logic [2:0] random_size;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28) return ACC_BYTE;
    if (r < 56) return ACC_WORD;
    if (r < 85) return ACC_LONG;
    return 3'($urandom_range(0, 7));
  endfunction

  // Aim most beats at a small hot region, so reads find earlier writes, with
  // the bits the mask strips left random. Some land on the memory-size edge,
  // the rest anywhere in the address space.
  function automatic logic [31:0] random_address;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return ($urandom & ~cur_mask) | 32'($urandom_range(0, 255));
    if (r < 80) return ($urandom & ~cur_mask) | (32'(cur_size) - 32'd8 + 32'($urandom_range(0, 15)));
    return $urandom;
  endfunction

  task automatic run_phase(input logic [31:0] mask, input logic [SIZE_W-1:0] size,
                           input int unsigned beats);
    set_config(mask, size);
    repeat (beats) begin
      send_cmd(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ, random_address(),
               random_size(), $urandom);
    end
  endtask

  initial begin
    // Hold every input at a known value and reset once.
    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_READ;
    address_i     = '0;
    access_size_i = ACC_BYTE;
    write_data_i  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ADDR_MASK;
    cfg_wdata_i   = '0;
    cur_mask      = ADDR_MASK_RST;
    cur_size      = MEM_SIZE_RST;
    beat_count    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the RAM clearing pass.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);

    // Directed beats on the reset settings.
    send_cmd(OP_WRITE, 32'h0000_0000, ACC_LONG, 32'hFFFF_FFFF);
    send_cmd(OP_READ,  32'h0000_0000, ACC_LONG, 32'h0000_0000);
    send_cmd(OP_WRITE, 32'h0000_0005, ACC_BYTE, 32'hFFFF_FFA5);
    send_cmd(OP_READ,  32'h0000_0005, ACC_BYTE, 32'hFFFF_FFFF);
    send_cmd(OP_WRITE, 32'h0000_0006, ACC_WORD, 32'h1234_BEEF);
    send_cmd(OP_READ,  32'h0000_0004, ACC_LONG, 32'h0000_0000);
    // word straddling the middle of a longword, then one across a boundary
    send_cmd(OP_WRITE, 32'h0000_0009, ACC_WORD, 32'hAAAA_5A5A);
    send_cmd(OP_READ,  32'h0000_0009, ACC_WORD, 32'h0000_0000);
    send_cmd(OP_WRITE, 32'h0000_000B, ACC_WORD, 32'h0000_C3D2);
    send_cmd(OP_READ,  32'h0000_000B, ACC_WORD, 32'h0000_0000);
    // split longwords at each byte offset
    send_cmd(OP_WRITE, 32'h0000_0011, ACC_LONG, 32'h0102_0304);
    send_cmd(OP_READ,  32'h0000_0011, ACC_LONG, 32'h0000_0000);
    send_cmd(OP_WRITE, 32'h0000_0016, ACC_LONG, 32'hCAFE_F00D);
    send_cmd(OP_READ,  32'h0000_0016, ACC_LONG, 32'h0000_0000);
    send_cmd(OP_WRITE, 32'h0000_001B, ACC_LONG, 32'h8765_4321);
    send_cmd(OP_READ,  32'h0000_0018, ACC_LONG, 32'h0000_0000);
    // odd width codes act as byte accesses
    send_cmd(OP_WRITE, 32'h0000_0021, 3'd0, 32'h0000_0077);
    send_cmd(OP_WRITE, 32'h0000_0022, 3'd3, 32'hFFFF_FF66);
    send_cmd(OP_WRITE, 32'h0000_0023, 3'd7, 32'hFFFF_FFFF);
    send_cmd(OP_READ,  32'h0000_0021, 3'd5, 32'h0000_0000);
    send_cmd(OP_READ,  32'h0000_0020, 3'd6, 32'hFFFF_FFFF);
    // top of memory: last longword in range, then one hanging past the end
    send_cmd(OP_WRITE, 32'h0000_FFFC, ACC_LONG, 32'hDEAD_BEEF);
    send_cmd(OP_WRITE, 32'h0000_FFFE, ACC_LONG, 32'h1357_9BDF);
    send_cmd(OP_READ,  32'h0000_FFFE, ACC_LONG, 32'h0000_0000);
    // everything set: masked to far beyond memory, reads zero
    send_cmd(OP_WRITE, 32'hFFFF_FFFF, ACC_LONG, 32'hFFFF_FFFF);
    send_cmd(OP_READ,  32'hFFFF_FFFF, ACC_BYTE, 32'h0000_0000);

    // Random phases across the settings, extremes among them.
    run_phase(32'hFFFF_FFFF, 17'h1_0000, 150);
    run_phase(32'h0000_FFFF, 17'd32768,  130);
    // both halves of a split access fold into one longword
    run_phase(32'h0000_0003, 17'd4096,    60);
    run_phase(32'h0000_003F, 17'd64,     100);
    // no memory at all and every address folded onto zero
    run_phase(32'h0000_0000, 17'd0,       40);
    run_phase($urandom, 17'($urandom_range(0, 65536)), 120);
    run_phase(32'h0001_FFFF, 17'h1_0000, 100);
    // size ending inside a longword
    run_phase(32'h3FFF_FFFF, 17'd1022,    60);
    run_phase(ADDR_MASK_RST, MEM_SIZE_RST, 190);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("unaligned_memory_access_unit regression: pass");
    end else begin
      $display("unaligned_memory_access_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("unaligned_memory_access_unit regression: fail");
    $finish;
  end

endmodule
